[design/hrr_pkg.sv]
// Shared types, constants and result helpers for the report reassembler.
// Used by every module of the block; depends on nothing.
package hrr_pkg;

    localparam int MSG_PAYLOAD_MAX    = 512;
    localparam int PACKET_PAYLOAD_MAX = 62;
    localparam int FILL_W             = 10;
    localparam int QDEPTH             = 4;
    localparam int QPTR_W             = 2;

    localparam logic [7:0] RESET_BYTE = 8'hFF;
    localparam logic [7:0] SEQ_STEP   = 8'h10;
    localparam logic [5:0] LEN_FAULT  = 6'd63;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SEQ     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic [FILL_W-1:0] count;
        logic              ack;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       r1;
        t_res       r0;
    } t_pair;

    function automatic t_res f_abort();
        t_res r;
        r       = '0;
        r.kind  = KIND_ABORT;
        return r;
    endfunction

    function automatic t_res f_done(logic [FILL_W-1:0] fill, logic ack);
        t_res r;
        r       = '0;
        r.kind  = KIND_DONE;
        r.count = fill;
        r.ack   = ack;
        return r;
    endfunction

    function automatic t_res f_data(logic [7:0] b, logic [FILL_W-1:0] fill);
        t_res r;
        r       = '0;
        r.kind  = KIND_DATA;
        r.data  = b;
        r.count = fill;
        return r;
    endfunction

    function automatic t_pair f_emit(t_pair p, t_res r);
        t_pair q;
        q = p;
        if (p.cnt == 2'd0) begin
            q.r0  = r;
            q.cnt = 2'd1;
        end else if (p.cnt == 2'd1) begin
            q.r1  = r;
            q.cnt = 2'd2;
        end
        return q;
    endfunction

    function automatic t_pair f_mark_last(t_pair p);
        t_pair q;
        q = p;
        if (p.cnt == 2'd1) begin
            q.r0.last = 1'b1;
        end else if (p.cnt == 2'd2) begin
            q.r1.last = 1'b1;
        end
        return q;
    endfunction

endpackage

[design/hrr_front.sv]
// Front end: parses the packet byte stream, keeps reassembly state and
// classifies each request into zero to two results. Depends on hrr_pkg.
module hrr_front import hrr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_req_type,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_pair      o_pair
);

    t_phase            r_phase,    n_phase;
    logic [7:0]        r_header,   n_header;
    logic [5:0]        r_left,     n_left;
    logic              r_exp_flip, n_exp_flip;
    logic [7:0]        r_exp_seq,  n_exp_seq;
    logic              r_open,     n_open;
    logic [FILL_W-1:0] r_fill,     n_fill;
    logic              r_acc,      n_acc;
    logic              r_final,    n_final;

    logic [5:0]  len;
    logic        v_acc;
    logic        v_start;
    logic        v_fin;
    logic [10:0] v_sum;
    t_pair       pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_header   <= '0;
            r_left     <= '0;
            r_exp_flip <= 1'b0;
            r_exp_seq  <= '0;
            r_open     <= 1'b0;
            r_fill     <= '0;
            r_acc      <= 1'b0;
            r_final    <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_header   <= n_header;
            r_left     <= n_left;
            r_exp_flip <= n_exp_flip;
            r_exp_seq  <= n_exp_seq;
            r_open     <= n_open;
            r_fill     <= n_fill;
            r_acc      <= n_acc;
            r_final    <= n_final;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_header   = r_header;
        n_left     = r_left;
        n_exp_flip = r_exp_flip;
        n_exp_seq  = r_exp_seq;
        n_open     = r_open;
        n_fill     = r_fill;
        n_acc      = r_acc;
        n_final    = r_final;
        len        = r_header[5:0];
        v_acc      = 1'b0;
        v_start    = 1'b0;
        v_fin      = 1'b0;
        v_sum      = '0;
        pair       = '0;

        if (i_req_type) begin
            if (r_open) begin
                pair = f_emit(pair, f_abort());
            end
            n_phase    = PH_HEADER;
            n_header   = '0;
            n_left     = '0;
            n_exp_flip = 1'b0;
            n_exp_seq  = '0;
            n_open     = 1'b0;
            n_fill     = '0;
            n_acc      = 1'b0;
            n_final    = 1'b0;
        end else begin
            case (r_phase)
                PH_SEQ: begin
                    n_acc   = 1'b0;
                    n_final = 1'b0;
                    n_phase = PH_HEADER;
                    n_left  = '0;
                    if (r_header == RESET_BYTE && i_byte == RESET_BYTE) begin
                        if (r_open) begin
                            pair = f_emit(pair, f_abort());
                        end
                        n_exp_flip = 1'b0;
                        n_open     = 1'b0;
                        n_fill     = '0;
                    end else if (len == LEN_FAULT) begin
                        if (r_open) begin
                            pair = f_emit(pair, f_abort());
                        end
                        n_header   = '0;
                        n_exp_flip = 1'b0;
                        n_exp_seq  = '0;
                        n_open     = 1'b0;
                        n_fill     = '0;
                    end else begin
                        if (r_header[7] == r_exp_flip) begin
                            if (r_open) begin
                                pair = f_emit(pair, f_abort());
                            end
                            n_exp_flip = ~r_exp_flip;
                            v_start    = 1'b1;
                            v_acc      = 1'b1;
                        end else if (!r_open) begin
                            v_acc = 1'b0;
                        end else if (i_byte != r_exp_seq) begin
                            pair   = f_emit(pair, f_abort());
                            n_open = 1'b0;
                            n_fill = '0;
                        end else begin
                            v_acc = 1'b1;
                        end

                        if (v_acc) begin
                            if (v_start) begin
                                n_open    = 1'b1;
                                n_fill    = '0;
                                n_exp_seq = i_byte;
                            end
                            v_sum = {5'd0, len} + {1'b0, n_fill};
                            if (v_sum > 11'(MSG_PAYLOAD_MAX)) begin
                                if (n_open) begin
                                    pair = f_emit(pair, f_abort());
                                end
                                n_open = 1'b0;
                                n_fill = '0;
                                v_acc  = 1'b0;
                            end else begin
                                v_fin = (i_byte[7:4] == i_byte[3:0]);
                                if (!v_fin) begin
                                    n_exp_seq = n_exp_seq + SEQ_STEP;
                                end
                                if (len == 6'd0 && v_fin) begin
                                    pair   = f_emit(pair, f_done(n_fill, r_header[6]));
                                    n_open = 1'b0;
                                    n_fill = '0;
                                end
                            end
                        end
                        n_acc   = v_acc;
                        n_final = v_fin;
                        if (len != 6'd0) begin
                            n_phase = PH_PAYLOAD;
                            n_left  = len;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_acc && r_open) begin
                        pair   = f_emit(pair, f_data(i_byte, r_fill));
                        n_fill = r_fill + 1'b1;
                    end
                    n_left = r_left - 1'b1;
                    if (n_left == 6'd0) begin
                        n_phase = PH_HEADER;
                        if (r_acc && r_final && r_open) begin
                            pair   = f_emit(pair, f_done(n_fill, r_header[6]));
                            n_open = 1'b0;
                            n_fill = '0;
                        end
                        n_acc   = 1'b0;
                        n_final = 1'b0;
                    end
                end
                default: begin
                    n_header = i_byte;
                    n_phase  = PH_SEQ;
                end
            endcase
        end
    end

    assign o_pair = f_mark_last(pair);
    assign o_push = i_fire && (pair.cnt != 2'd0);

endmodule

[design/hrr_queue.sv]
// Short queue of result pairs between the parser and the output stage.
// Depends on hrr_pkg.
module hrr_queue import hrr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    input  logic  i_pop,
    output logic  o_ready,
    output logic  o_valid,
    output t_pair o_pair
);

    t_pair             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_ready = (r_cnt != (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_pair  = r_mem[r_rptr];

endmodule

[design/hrr_back.sv]
// Output stage: splits queued pairs into single results and holds them in
// the output register until taken. Depends on hrr_pkg.
module hrr_back import hrr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_pair i_q_pair,
    input  logic  i_ready,
    output logic  o_pop,
    output logic  o_valid,
    output t_res  o_res
);

    logic r_valid;
    logic r_sel;
    t_res r_res;
    logic load;
    logic at_end;

    assign load   = i_q_valid && (!r_valid || i_ready);
    assign at_end = r_sel || (i_q_pair.cnt == 2'd1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !at_end;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= r_sel ? i_q_pair.r1 : i_q_pair.r0;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[design/hid_report_reassembler.sv]
// Top level of the report reassembler: parser, pair queue and output stage.
// Depends on hrr_pkg, hrr_front, hrr_queue and hrr_back.
//
// Takes one stream byte per cycle while the queue has room (tuser high means
// host link lost) and streams payload bytes, completion and abort results,
// one per cycle while tready is high. Most requests give at most one result
// and pass at full rate; a request giving two results (data plus completion,
// or abort plus completion) is handed out as two separate results, and a
// four-entry pair queue between parser and output register absorbs these so
// input stalls only when the queue is full, which back-pressure from a low
// downstream tready can cause. A result passes the pair queue, then the output register.
module hid_report_reassembler import hrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] stream_byte
    input  logic        i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [17:8] count, [18] ack_wanted
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last
);

    logic  fire;
    logic  push;
    t_pair f_pair;
    logic  q_ready;
    logic  q_valid;
    t_pair q_pair;
    logic  pop;
    logic  b_valid;
    t_res  b_res;

    assign fire = i_s_axis_tvalid && q_ready;

    hrr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req_type (i_s_axis_tuser),
        .i_byte     (i_s_axis_tdata),
        .o_push     (push),
        .o_pair     (f_pair)
    );

    hrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (f_pair),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_pair  (q_pair)
    );

    hrr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_pair  (q_pair),
        .i_ready   (i_m_axis_tready),
        .o_pop     (pop),
        .o_valid   (b_valid),
        .o_res     (b_res)
    );

    assign o_s_axis_tready = q_ready;
    assign o_m_axis_tvalid = b_valid;
    assign o_m_axis_tdata  = {5'd0, b_res.ack, b_res.count, b_res.data};
    assign o_m_axis_tuser  = b_res.kind;
    assign o_m_axis_tlast  = b_res.last;

endmodule

[design/hrr_checker.sv]
// Port-level checks for the report reassembler, bound to the top level.
// Depends on hrr_pkg and hid_report_reassembler.
module hrr_checker import hrr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_ABORT |->
            o_m_axis_tdata == 24'd0)
        else $error("abort result carries data");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_DONE |->
            o_m_axis_tdata[7:0] == 8'd0 && o_m_axis_tdata[17:8] <= 10'(MSG_PAYLOAD_MAX)
            && o_m_axis_tlast)
        else $error("completion result malformed");

    a_data_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_DATA |->
            !o_m_axis_tdata[18] && o_m_axis_tdata[17:8] < 10'(MSG_PAYLOAD_MAX))
        else $error("payload offset beyond message limit");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3 && o_m_axis_tdata[23:19] == 5'd0)
        else $error("invalid result kind or padding");

endmodule

bind hid_report_reassembler hrr_checker u_hrr_checker (.*);

[tb/tb_hid_report_reassembler.sv]
// Testbench for hid_report_reassembler: random and directed report packets in,
// results checked against a predictor kept inside this file.
// Depends on hrr_pkg and the hid_report_reassembler design files.
module tb_hid_report_reassembler;
    import hrr_pkg::*;

    localparam int IDLE_PCT    = 23;
    localparam int STALL_LIMIT = 2000;
    localparam int TOTAL_REQS  = 1150;

    typedef struct packed {
        logic       lost;
        logic [7:0] value;
    } t_stream_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] stream_byte
    logic        i_s_axis_tuser = 1'b0;    // [0] req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;           // [7:0] data_byte, [17:8] count, [18] ack_wanted
    logic [1:0]  o_m_axis_tuser;           // [1:0] kind
    logic        o_m_axis_tlast;

    hid_report_reassembler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_stream_req stream_reqs[$];
    t_res        pending_results[$];
    t_res        step_results[$];

    int   n_total = 0;
    int   n_sent = 0;
    int   n_taken = 0;
    int   n_errors = 0;
    int   n_bytes = 0;
    int   n_done = 0;
    int   n_abort = 0;
    int   stall_cycles = 0;
    bit   req_taken = 1'b0;
    logic gen_flip = 1'b0;
    logic steady;

    assign steady = (n_sent >= 400) && (n_sent < 700);

    // predictor state
    t_phase            rx_phase;
    logic [7:0]        rx_header;
    logic [5:0]        rx_left;
    logic              rx_flip;
    logic [7:0]        rx_seq;
    logic              msg_open;
    logic [FILL_W-1:0] msg_fill;
    logic              pkt_taken;
    logic              pkt_final;

    task automatic report(input string what, input int got, input int want);
        if (n_errors < 20) begin
            $display("mismatch on %s: got %0d, expected %0d (request %0d)",
                     what, got, want, n_taken);
        end
        n_errors++;
    endtask

    task automatic put_result(input t_kind kind, input logic [7:0] data,
                              input logic [FILL_W-1:0] count, input logic ack);
        t_res r;
        r       = '0;
        r.kind  = kind;
        r.data  = data;
        r.count = count;
        r.ack   = ack;
        if (step_results.size() < 2) begin
            step_results.push_back(r);
        end
    endtask

    task automatic drop_message();
        if (msg_open) begin
            put_result(KIND_ABORT, 8'h00, '0, 1'b0);
        end
        msg_open = 1'b0;
        msg_fill = '0;
    endtask

    task automatic close_message();
        put_result(KIND_DONE, 8'h00, msg_fill, rx_header[6]);
        msg_open = 1'b0;
        msg_fill = '0;
    endtask

    task automatic clear_reassembly();
        rx_phase  = PH_HEADER;
        rx_header = '0;
        rx_left   = '0;
        rx_flip   = 1'b0;
        rx_seq    = '0;
        msg_open  = 1'b0;
        msg_fill  = '0;
        pkt_taken = 1'b0;
        pkt_final = 1'b0;
    endtask

    task automatic reassemble_byte(input logic lost, input logic [7:0] b);
        logic [5:0] len;
        logic       start;
        t_res       r;
        step_results.delete();
        len   = rx_header[5:0];
        start = 1'b0;
        if (lost) begin
            drop_message();
            clear_reassembly();
        end else begin
            case (rx_phase)
                PH_SEQ: begin
                    pkt_taken = 1'b0;
                    pkt_final = 1'b0;
                    rx_phase  = PH_HEADER;
                    rx_left   = '0;
                    if (rx_header == RESET_BYTE && b == RESET_BYTE) begin
                        rx_flip = 1'b0;
                        drop_message();
                    end else if (len > PACKET_PAYLOAD_MAX) begin
                        drop_message();
                        clear_reassembly();
                    end else begin
                        if (rx_header[7] == rx_flip) begin
                            drop_message();
                            rx_flip   = ~rx_flip;
                            start     = 1'b1;
                            pkt_taken = 1'b1;
                        end else if (!msg_open) begin
                            pkt_taken = 1'b0;
                        end else if (b != rx_seq) begin
                            drop_message();
                            pkt_taken = 1'b0;
                        end else begin
                            pkt_taken = 1'b1;
                        end
                        if (pkt_taken) begin
                            if (start) begin
                                msg_open = 1'b1;
                                msg_fill = '0;
                                rx_seq   = b;
                            end
                            if (int'(len) + int'(msg_fill) > MSG_PAYLOAD_MAX) begin
                                drop_message();
                                pkt_taken = 1'b0;
                            end else begin
                                pkt_final = (b[7:4] == b[3:0]);
                                if (!pkt_final) begin
                                    rx_seq = rx_seq + SEQ_STEP;
                                end
                                if (len == 6'd0 && pkt_final) begin
                                    close_message();
                                end
                            end
                        end
                        if (len != 6'd0) begin
                            rx_phase = PH_PAYLOAD;
                            rx_left  = len;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (pkt_taken && msg_open) begin
                        put_result(KIND_DATA, b, msg_fill, 1'b0);
                        msg_fill = msg_fill + 1'b1;
                    end
                    rx_left = rx_left - 1'b1;
                    if (rx_left == 6'd0) begin
                        rx_phase = PH_HEADER;
                        if (pkt_taken && pkt_final && msg_open) begin
                            close_message();
                        end
                        pkt_taken = 1'b0;
                        pkt_final = 1'b0;
                    end
                end
                default: begin
                    rx_header = b;
                    rx_phase  = PH_SEQ;
                end
            endcase
        end
        if (step_results.size() != 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
        foreach (step_results[i]) begin
            r = step_results[i];
            pending_results.push_back(r);
        end
    endtask

    task automatic push_req(input logic lost, input logic [7:0] value);
        t_stream_req q;
        q.lost  = lost;
        q.value = value;
        stream_reqs.push_back(q);
    endtask

    task automatic push_lost();
        push_req(1'b1, 8'($urandom_range(0, 255)));
        gen_flip = 1'b0;
    endtask

    task automatic push_packet(input logic flip, input logic ack, input int len,
                               input logic [7:0] seq);
        push_req(1'b0, {flip, ack, 6'(len)});
        push_req(1'b0, seq);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_req(1'b0, $urandom_range(0, 1) ? 8'hFF : 8'h00);
            end else begin
                push_req(1'b0, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic push_message(input int npk, input int plen, input bit faults);
        logic [7:0] sb;
        int         len;
        int         base;
        base = faults ? $urandom_range(0, 15) : 0;
        for (int i = 0; i < npk; i++) begin
            if (plen >= 0) begin
                len = plen;
            end else if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(0, PACKET_PAYLOAD_MAX);
            end else begin
                len = $urandom_range(0, 6);
            end
            sb = {4'(base + i), 4'(base + npk - 1)};
            if (faults && i > 0 && $urandom_range(0, 9) == 0) begin
                sb = sb ^ 8'($urandom_range(1, 255));
            end
            if (faults && $urandom_range(0, 29) == 0) begin
                push_lost();
                return;
            end
            push_packet(gen_flip, 1'($urandom_range(0, 1)), len, sb);
            if (faults && i < npk - 1 && $urandom_range(0, 19) == 0) begin
                break;
            end
        end
        gen_flip = ~gen_flip;
    endtask

    task automatic push_long_message(input int last_len);
        for (int i = 0; i < 9; i++) begin
            push_packet(gen_flip, 1'($urandom_range(0, 1)),
                        (i < 8) ? PACKET_PAYLOAD_MAX : last_len, {4'(i), 4'd8});
        end
        gen_flip = ~gen_flip;
    endtask

    always @(negedge i_clk) begin : drive
        t_stream_req q;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || req_taken) begin
                if (stream_reqs.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    q = stream_reqs.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= q.value;
                    i_s_axis_tuser  <= q.lost;
                    n_sent++;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
        req_taken = 1'b0;
    end

    always @(posedge i_clk) begin : observe
        t_res want;
        bit   progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                reassemble_byte(i_s_axis_tuser, i_s_axis_tdata);
                n_taken++;
                req_taken = 1'b1;
                progress  = 1'b1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                progress = 1'b1;
                case (o_m_axis_tuser)
                    KIND_DATA:  n_bytes++;
                    KIND_DONE:  n_done++;
                    KIND_ABORT: n_abort++;
                    default: ;
                endcase
                if (pending_results.size() == 0) begin
                    report("result with nothing expected, kind", o_m_axis_tuser, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_axis_tuser != want.kind) begin
                        report("kind", o_m_axis_tuser, want.kind);
                    end
                    if (o_m_axis_tdata[7:0] != want.data) begin
                        report("data_byte", o_m_axis_tdata[7:0], want.data);
                    end
                    if (o_m_axis_tdata[17:8] != want.count) begin
                        report("count", o_m_axis_tdata[17:8], want.count);
                    end
                    if (o_m_axis_tdata[18] != want.ack) begin
                        report("ack_wanted", o_m_axis_tdata[18], want.ack);
                    end
                    if (o_m_axis_tlast != want.last) begin
                        report("last", o_m_axis_tlast, want.last);
                    end
                    if (o_m_axis_tdata[23:19] != '0) begin
                        report("tdata padding", o_m_axis_tdata[23:19], 0);
                    end
                end
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL hid_report_reassembler");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int r;
        int k;
        clear_reassembly();

        // directed: empty message, reset and length fault packets, bad flip,
        // bad sequence, link lost, restart while open, payload extremes
        push_message(1, 0, 1'b0);
        push_packet(gen_flip, 1'b0, 1, 8'h01);
        gen_flip = ~gen_flip;
        push_req(1'b0, RESET_BYTE);
        push_req(1'b0, RESET_BYTE);
        gen_flip = 1'b0;
        push_packet(gen_flip, 1'b1, 1, 8'h01);
        push_req(1'b0, {~gen_flip, 1'b1, LEN_FAULT});
        push_req(1'b0, 8'h00);
        gen_flip = 1'b0;
        push_packet(~gen_flip, 1'b0, 1, 8'h00);
        push_packet(gen_flip, 1'b0, 1, 8'h02);
        push_packet(gen_flip, 1'b0, 1, 8'h22);
        gen_flip = ~gen_flip;
        push_packet(gen_flip, 1'b0, 1, 8'h01);
        push_lost();
        push_packet(gen_flip, 1'b1, 0, 8'h01);
        gen_flip = ~gen_flip;
        push_message(2, 0, 1'b0);
        push_req(1'b0, {gen_flip, 1'b1, 6'd2});
        push_req(1'b0, 8'h00);
        push_req(1'b0, 8'h00);
        push_req(1'b0, 8'hFF);
        gen_flip = ~gen_flip;
        push_req(1'b0, RESET_BYTE);
        push_req(1'b0, RESET_BYTE);
        gen_flip = 1'b0;

        // random traffic plus one message up to the length limit, ending exactly on it or one over
        k = 0;
        while (stream_reqs.size() < TOTAL_REQS) begin
            if (k == 10) begin
                push_long_message(16 + int'($urandom_range(0, 1)));
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                push_message(($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
                                                         : $urandom_range(1, 3), -1, 1'b1);
            end else if (r < 75) begin
                repeat ($urandom_range(1, 6)) push_req(1'b0, 8'($urandom_range(0, 255)));
                push_lost();
            end else if (r < 82) begin
                push_req(1'b0, RESET_BYTE);
                push_req(1'b0, RESET_BYTE);
                gen_flip = 1'b0;
            end else if (r < 88) begin
                push_req(1'b0, {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), LEN_FAULT});
                push_req(1'b0, 8'($urandom_range(0, 255)));
                gen_flip = 1'b0;
            end else if (r < 94) begin
                push_packet(~gen_flip, 1'($urandom_range(0, 1)), $urandom_range(0, 6),
                            8'($urandom_range(0, 255)));
            end else begin
                push_lost();
            end
            k++;
        end
        n_total = stream_reqs.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (n_taken != n_total || pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report("results still outstanding", 0, pending_results.size());
        end

        $display("%0d stream requests sent; %0d payload bytes, %0d messages completed,",
                 n_taken, n_bytes, n_done);
        $display("%0d messages aborted, %0d mismatches", n_abort, n_errors);
        if (n_errors == 0) begin
            $display("PASS hid_report_reassembler");
        end else begin
            $display("FAIL hid_report_reassembler");
        end
        $finish;
    end

endmodule
